// ===== rtl/boxcar_bin_averager_core_defines.svh =====
// Assertion macros for the boxcar bin averager.
// Included by the modules that carry concurrent checks; needs signals clk and rst in scope.
`ifndef BOXCAR_BIN_AVERAGER_CORE_DEFINES_SVH
`define BOXCAR_BIN_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba check failed");

`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants and types for the boxcar bin averager.
// No dependencies; imported by every module of the block.
package bba_pkg;

  // Fixed port widths.
  localparam int VALUE_W = 24;
  localparam int TIME_W  = 48;
  localparam int SIZE_W  = 16;
  localparam int MEAN_W  = 32;

  // Width used for comparing the bin size with the sample count.
  localparam int CMP_W = 32;

  // Default datapath widths.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int FRAC_BITS_DEF   = 8;

  // Depth of the queue between the front and the divider; a power of two.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/bba_front.sv =====
// Front end of the boxcar bin averager: bin size register, running sum and count.
// Depends on bba_pkg; pushes closed bins into bba_queue.
module bba_front import bba_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int SUM_BITS    = SAMPLE_BITS + COUNT_BITS,
  parameter int BIN_W       = SUM_BITS + COUNT_BITS + TIME_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bin_size_we,
  input  logic [SIZE_W-1:0]  bin_size_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] sample_value,
  input  logic [TIME_W-1:0]  sample_time,
  input  logic               sample_last,
  input  logic               q_full,
  output logic               q_push,
  output logic [BIN_W-1:0]   q_data
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [SIZE_W-1:0]     bin_size;
  logic [SUM_BITS-1:0]   bin_sum;
  logic [COUNT_BITS-1:0] bin_count;
  logic [TIME_BITS-1:0]  bin_start_time;

  logic [SUM_BITS-1:0]   sum_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [TIME_BITS-1:0]  start_next;

  logic [SAMPLE_BITS+VALUE_W-1:0] value_ext;
  logic [TIME_BITS+TIME_W-1:0]    time_ext;
  logic [CMP_W-1:0]               size_ext;
  logic [CMP_W-1:0]               size_eff;
  logic                           accept;
  logic                           close;

  assign value_ext = {{SAMPLE_BITS{1'b0}}, sample_value};
  assign time_ext  = {{TIME_BITS{1'b0}}, sample_time};

  // A size of zero behaves as one; a size beyond the counter is clipped to its maximum.
  assign size_ext = CMP_W'(bin_size);
  always_comb begin
    if (bin_size == '0) begin
      size_eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(CountMax)) begin
      size_eff = CMP_W'(CountMax);
    end else begin
      size_eff = size_ext;
    end
  end

  assign sum_next   = bin_sum + SUM_BITS'(value_ext[SAMPLE_BITS-1:0]);
  assign count_next = (bin_count != CountMax) ? bin_count + 1'b1 : bin_count;
  assign start_next = (bin_count == '0) ? time_ext[TIME_BITS-1:0] : bin_start_time;

  assign close    = (CMP_W'(count_next) >= size_eff) || sample_last;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && close;
  assign q_data   = {sum_next, count_next, start_next, sample_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size       <= SIZE_W'(1);
      bin_sum        <= '0;
      bin_count      <= '0;
      bin_start_time <= '0;
    end else begin
      if (bin_size_we) begin
        bin_size <= bin_size_wdata;
      end
      if (accept) begin
        if (close) begin
          bin_sum        <= '0;
          bin_count      <= '0;
          bin_start_time <= '0;
        end else begin
          bin_sum        <= sum_next;
          bin_count      <= count_next;
          bin_start_time <= start_next;
        end
      end
    end
  end

endmodule

// ===== rtl/bba_queue.sv =====
// Small register queue that decouples the bin front end from the divider.
// Depends on bba_pkg for the default depth.
module bba_queue import bba_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign valid    = (fill != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bba_divider.sv =====
// Back end of the boxcar bin averager: bit-serial restoring divider and output register.
// Depends on bba_pkg and the assertion macros; takes closed bins from bba_queue.
`include "boxcar_bin_averager_core_defines.svh"
module bba_divider import bba_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SUM_BITS   = SAMPLE_BITS_DEF + COUNT_BITS_DEF,
  parameter int BIN_W      = SUM_BITS + COUNT_BITS + TIME_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [BIN_W-1:0]  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MEAN_W-1:0] bin_mean,
  output logic [TIME_W-1:0] bin_time,
  output logic              bin_last
);

  localparam int DIV_BITS = SUM_BITS + FRAC_BITS;
  localparam int STEP_W   = $clog2(DIV_BITS);

  back_state_t state, state_next;

  logic [SUM_BITS-1:0]   in_sum;
  logic [COUNT_BITS-1:0] in_count;
  logic [TIME_BITS-1:0]  in_time;
  logic                  in_last;

  logic [DIV_BITS-1:0]   dq;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] divisor;
  logic [TIME_BITS-1:0]  start_time;
  logic                  last_flag;
  logic [STEP_W-1:0]     step;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic                  load_out;

  logic [DIV_BITS+MEAN_W-1:0]  q_ext;
  logic [TIME_BITS+TIME_W-1:0] t_ext;
  logic                        overflow;

  assign {in_sum, in_count, in_time, in_last} = q_data;

  // One quotient bit per cycle; the dividend register fills with quotient bits from the bottom.
  assign trial = {rem, dq[DIV_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  assign q_ext    = {{MEAN_W{1'b0}}, dq};
  assign overflow = |q_ext[DIV_BITS+MEAN_W-1:MEAN_W];
  assign t_ext    = {{TIME_W{1'b0}}, start_time};

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == STEP_W'(DIV_BITS - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dq         <= DIV_BITS'(in_sum) << FRAC_BITS;
      rem        <= '0;
      divisor    <= in_count;
      start_time <= in_time;
      last_flag  <= in_last;
      step       <= '0;
    end else if (state == BK_DIV) begin
      dq   <= {dq[DIV_BITS-2:0], ge};
      rem  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      step <= step + 1'b1;
    end
    if (load_out) begin
      bin_mean <= overflow ? '1 : q_ext[MEAN_W-1:0];
      bin_time <= t_ext[TIME_W-1:0];
      bin_last <= last_flag;
    end
  end

  `BBA_ASSERT_NOW(a_divisor_nonzero, state == BK_DIV, divisor != '0)
  `BBA_ASSERT_NOW(a_rem_below_divisor, state == BK_DIV, rem < divisor)
  `BBA_ASSERT_NOW(a_pop_only_idle, q_pop, (state == BK_IDLE) && q_valid)
  `BBA_ASSERT_NEXT(a_done_loads_out, load_out, out_valid && (state == BK_IDLE))

endmodule

// ===== rtl/boxcar_bin_averager_core.sv =====
// Top level of the boxcar bin averager: front end, bin queue and divider back end.
// Depends on bba_pkg, bba_front, bba_queue and bba_divider.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   config   | bin_size_we                | bin_size_wdata
//   input    | in_valid / in_ready        | sample_value, sample_time, sample_last
//   output   | out_valid / out_ready      | bin_mean, bin_time, bin_last
//
// The front end takes one word per cycle while the bin queue has room; once the queue is
// full, in_ready falls for every word, closing or not, until the divider frees an entry.
// For each closed bin the divider takes the bin from the queue, works out its quotient bits one
// at a time and then loads the output register; only then does it take the next bin from the queue.
// Reset is synchronous and active high: bin size one, empty open bin and queue, no out_valid.
// A stalled output holds its word while the divider finishes the next bin and then waits.
module boxcar_bin_averager_core import bba_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bin_size_we,
  input  logic [SIZE_W-1:0]  bin_size_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] sample_value,
  input  logic [TIME_W-1:0]  sample_time,
  input  logic               sample_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MEAN_W-1:0]  bin_mean,
  output logic [TIME_W-1:0]  bin_time,
  output logic               bin_last
);

  // A closed bin carries its sum, sample count, start time and last flag.
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int BIN_W    = SUM_BITS + COUNT_BITS + TIME_BITS + 1;

  logic             q_push;
  logic [BIN_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  logic [BIN_W-1:0] q_pop_data;

  // The front end accumulates samples and hands over each bin as it closes.
  bba_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .TIME_BITS   (TIME_BITS),
    .SUM_BITS    (SUM_BITS),
    .BIN_W       (BIN_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .bin_size_we    (bin_size_we),
    .bin_size_wdata (bin_size_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .sample_time    (sample_time),
    .sample_last    (sample_last),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  // The queue lets the front keep taking samples while the divider is busy.
  bba_queue #(
    .WIDTH (BIN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // The back end divides each bin's sum by its count and presents the result.
  bba_divider #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .SUM_BITS   (SUM_BITS),
    .BIN_W      (BIN_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_mean  (bin_mean),
    .bin_time  (bin_time),
    .bin_last  (bin_last)
  );

endmodule
